[src/hsc_pkg.sv]
// Shared types and constants for the heightmap splat/classify unit.
// No dependencies.
package hsc_pkg;
  localparam int unsigned MaxWidth   = 64;
  localparam int unsigned MaxHeight  = 64;
  localparam int unsigned MaxRadius  = 15;
  localparam int unsigned HeightBits = 24;
  localparam int unsigned AddrBits   = 12;

  localparam logic [1:0] OpDrop  = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  localparam logic [2:0] RegGridWidth  = 3'd0;
  localparam logic [2:0] RegGridHeight = 3'd1;
  localparam logic [2:0] RegDropRadius = 3'd2;
  localparam logic [2:0] RegDropPower  = 3'd3;
  localparam logic [2:0] RegWaterLevel = 3'd4;

  // Command from sequencer to the divider.
  typedef struct packed {
    logic                  start;
    logic [HeightBits+7:0] dividend;
    logic [HeightBits-1:0] divisor;
  } div_req_t;

  // floor(v*pct/100) for v <= 255, pct <= 100; the divide by 100 is
  // p*5243 >> 19, exact for p <= 25500.
  function automatic logic [7:0] pct_of(input logic [7:0] v, input logic [6:0] pct);
    logic [15:0] p;
    logic [31:0] q;
    p = 16'(v) * 16'(pct);
    q = 32'(p) * 32'd5243;
    return q[26:19];
  endfunction
endpackage

[src/hsc_divider.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on hsc_pkg.
module hsc_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hsc_pkg::div_req_t                   req_i,
  output logic                                busy_o,
  output logic [hsc_pkg::HeightBits+7:0]      quot_o
);
  import hsc_pkg::*;
  localparam int unsigned NBits = HeightBits + 8;

  logic [NBits-1:0]      quot_q;
  logic [HeightBits:0]   rem_q;
  logic [HeightBits-1:0] dsr_q;
  logic [5:0]            cnt_q;
  logic                  busy_q;
  logic [HeightBits:0]   trial;
  logic [HeightBits:0]   shifted;

  always_comb begin
    shifted = {rem_q[HeightBits-1:0], quot_q[NBits-1]};
    trial   = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(NBits);
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[HeightBits]) begin
        rem_q  <= trial;
        quot_q <= {quot_q[NBits-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        quot_q <= {quot_q[NBits-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

[src/heightmap_splat_classify_unit.sv]
// Heightmap splat/classify unit: top level with grid memory and sequencer.
// Depends on hsc_pkg and hsc_divider.
//
// One transaction at a time. A drop walks the (2r+1)^2 window around the
// centre, visiting each cell with a memory read, then an add and write back,
// and the read state also steps a root counter that tracks the integer square
// root of the squared distance. A read waits for the serial divide. A clear
// sweeps all 4096 cells, one a cycle. After reset a clearing pass over all
// cells runs before the first item is accepted.
module heightmap_splat_classify_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // op[1:0], pos_x[7:2], pos_y[13:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // status[0], raw_height[24:1], level[32:25], terrain[35:33]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hsc_pkg::*;

  typedef enum logic [3:0] {
    StClr, StIdle, StDrRd, StDrWr, StRdRd, StRdDiv, StRdWait, StOut
  } state_e;

  state_e state_q;
  logic [6:0] gw_q, gh_q;
  logic [3:0] rad_q;
  logic [7:0] pow_q, wl_q;
  logic [HeightBits-1:0] peak_q;
  logic [HeightBits-1:0] mem [MaxWidth*MaxHeight];
  logic [HeightBits-1:0] rdata_q;
  logic [AddrBits-1:0]   addr_q;
  logic [6:0] cx_q, cy_q;
  logic signed [5:0] dx_q, dy_q;
  logic [4:0] sq_q;  // isqrt of current d2
  logic [1:0] op_q;
  logic [39:0] out_q;
  div_req_t div_req;
  logic div_busy;
  logic [HeightBits+7:0] quot;

  hsc_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .busy_o(div_busy), .quot_o(quot));

  // config port
  logic wr_en;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign ridx = paddr[4:2];
  always_comb begin
    unique case (ridx)
      RegGridWidth:  prdata = 32'(gw_q);
      RegGridHeight: prdata = 32'(gh_q);
      RegDropRadius: prdata = 32'(rad_q);
      RegDropPower:  prdata = 32'(pow_q);
      RegWaterLevel: prdata = 32'(wl_q);
      default:       prdata = '0;
    endcase
  end

  logic [6:0] uw, uh;
  logic [3:0] ur;
  assign uw = (gw_q > 7'(MaxWidth)) ? 7'(MaxWidth) : gw_q;
  assign uh = (gh_q > 7'(MaxHeight)) ? 7'(MaxHeight) : gh_q;
  assign ur = rad_q;  // 4 bits cannot exceed MaxRadius

  // current cell of drop walk
  logic signed [7:0] xs, ys;
  logic signed [9:0] dxe, dye;
  logic [9:0] d2, r2, nsq;
  logic cell_ok;
  assign xs = $signed({1'b0, cx_q}) + 8'(dx_q);
  assign ys = $signed({1'b0, cy_q}) + 8'(dy_q);
  assign dxe = 10'(dx_q);
  assign dye = 10'(dy_q);
  assign d2 = $unsigned(dxe * dxe) + $unsigned(dye * dye);
  assign r2 = 10'(ur) * 10'(ur);
  assign nsq = (10'(sq_q) + 10'd1) * (10'(sq_q) + 10'd1);
  assign cell_ok = !xs[7] && !ys[7] && (xs < $signed({1'b0, uw}))
                 && (ys < $signed({1'b0, uh})) && (d2 <= r2);

  logic [AddrBits-1:0] cell_addr;
  assign cell_addr = {ys[5:0], xs[5:0]};

  logic [7:0] step_pow;
  logic [HeightBits:0] sum;
  logic [HeightBits-1:0] sat;
  assign step_pow = (pow_q > 8'(sq_q)) ? pow_q - 8'(sq_q) : 8'd0;
  assign sum = {1'b0, rdata_q} + (HeightBits+1)'(step_pow);
  assign sat = sum[HeightBits] ? '1 : sum[HeightBits-1:0];

  logic [7:0] lvl;
  logic [2:0] terr;
  assign lvl = (peak_q == '0) ? 8'd0 : ((|quot[HeightBits+7:8]) ? 8'hff : quot[7:0]);
  always_comb begin
    logic [7:0] lz;
    lz = 8'd255 - wl_q;
    priority if (lvl < (wl_q >> 1)) terr = 3'd0;
    else if (lvl <= wl_q) terr = 3'd1;
    else if (9'(lvl) < 9'(wl_q) + 9'(pct_of(lz, 7'd15))) terr = 3'd2;
    else if (9'(lvl) < 9'(wl_q) + 9'(pct_of(lz, 7'd40))) terr = 3'd3;
    else if (9'(lvl) < 9'(wl_q) + 9'(pct_of(lz, 7'd80))) terr = 3'd4;
    else terr = 3'd5;
  end

  logic [5:0] px, py;
  logic pos_ok;
  assign px = s_axis_tdata_i[7:2];
  assign py = s_axis_tdata_i[13:8];
  assign pos_ok = (7'(px) < uw) && (7'(py) < uh);

  always_comb begin
    div_req.start    = (state_q == StRdDiv);
    div_req.dividend = (HeightBits+8)'(rdata_q) * (HeightBits+8)'(255);
    div_req.divisor  = peak_q;
  end

  // memory; during the drop walk the read follows the cell being visited
  logic mem_we;
  logic [AddrBits-1:0] mem_wa;
  logic [AddrBits-1:0] mem_ra;
  logic [HeightBits-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wa = addr_q; mem_wd = '0;
    if (state_q == StClr) mem_we = 1'b1;
    else if (state_q == StDrWr && cell_ok) begin
      mem_we = 1'b1; mem_wd = sat;
    end
  end
  assign mem_ra = (state_q == StDrRd) ? cell_addr : addr_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  logic last_cell;
  assign last_cell = (dx_q == $signed(6'(ur))) && (dy_q == $signed(6'(ur)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr; addr_q <= '0; peak_q <= '0;
      gw_q <= 7'd64; gh_q <= 7'd64; rad_q <= 4'd2; pow_q <= 8'd2; wl_q <= 8'd40;
      op_q <= '0; out_q <= '0;
      cx_q <= '0; cy_q <= '0; dx_q <= '0; dy_q <= '0; sq_q <= '0;
    end else begin
      if (wr_en) begin
        unique case (ridx)
          RegGridWidth:  gw_q  <= pwdata[6:0];
          RegGridHeight: gh_q  <= pwdata[6:0];
          RegDropRadius: rad_q <= pwdata[3:0];
          RegDropPower:  pow_q <= pwdata[7:0];
          RegWaterLevel: wl_q  <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StClr: begin
          addr_q <= addr_q + 1'b1;
          // a clear started from idle ends with a result
          if (&addr_q) state_q <= (op_q == OpClear) ? StOut : StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid_i) begin
            op_q  <= s_axis_tdata_i[1:0];
            out_q <= '0;
            cx_q <= 7'(px); cy_q <= 7'(py);
            addr_q <= {py, px};
            unique case (s_axis_tdata_i[1:0])
              OpDrop: begin
                if (!pos_ok) begin out_q[0] <= 1'b1; state_q <= StOut; end
                else begin
                  dx_q <= -$signed(6'(ur)); dy_q <= -$signed(6'(ur));
                  sq_q <= '0; state_q <= StDrRd;
                end
              end
              OpRead: begin
                if (!pos_ok) begin out_q[0] <= 1'b1; state_q <= StOut; end
                else state_q <= StRdRd;
              end
              OpClear: begin
                peak_q <= '0; addr_q <= '0; state_q <= StClr;
              end
              default: state_q <= StOut;
            endcase
          end
        end
        StDrRd: begin
          addr_q <= cell_addr;
          // advance root so that sq_q = isqrt(d2); d2 changes little per cell
          if (nsq <= d2) sq_q <= sq_q + 5'd1;
          else if (10'(sq_q) * 10'(sq_q) > d2) sq_q <= sq_q - 5'd1;
          else state_q <= StDrWr;
        end
        StDrWr: begin
          if (cell_ok && sat > peak_q) peak_q <= sat;
          if (last_cell) state_q <= StOut;
          else begin
            if (dx_q == $signed(6'(ur))) begin
              dx_q <= -$signed(6'(ur)); dy_q <= dy_q + 6'sd1;
            end else dx_q <= dx_q + 6'sd1;
            state_q <= StDrRd;
          end
        end
        StRdRd:  state_q <= StRdDiv;
        StRdDiv: state_q <= StRdWait;
        StRdWait: begin
          if (!div_busy) begin
            out_q <= {4'd0, terr, lvl, rdata_q, 1'b0};
            state_q <= StOut;
          end
        end
        StOut: if (m_axis_tready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = out_q;

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("out with ready");
  a_peak_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] == OpClear)
      |=> peak_q == '0) else $error("peak not cleared");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy) else $error("div busy at idle");
endmodule

[tb/tb.sv]
// Testbench for heightmap_splat_classify_unit: directed and random drop/read/clear
// traffic checked against an in-bench height grid predictor. Depends on hsc_pkg and the DUT.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsc_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] x;
    logic [5:0] y;
  } cell_cmd_t;

  // lowest bit last, matching the output tdata layout
  typedef struct packed {
    logic [2:0]  terrain;
    logic [7:0]  level;
    logic [23:0] raw;
    logic        status;
  } cell_answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // op[1:0], pos_x[7:2], pos_y[13:8]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // status[0], raw[24:1], level[32:25], terrain[35:33]
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  heightmap_splat_classify_unit i_dut (.*);

  cell_cmd_t    cmd_q[$];
  cell_answer_t answer_q[$];
  cell_cmd_t    cur_cmd;
  int unsigned  errors = 0;
  bit           src_noisy = 1, sink_noisy = 1, hold_req = 0;
  int unsigned  hold_cnt = 0;

  // grid model
  logic [23:0] height_grid[MaxWidth*MaxHeight];
  logic [23:0] peak_h;
  logic [6:0]  cfg_w, cfg_h;
  logic [3:0]  cfg_r;
  logic [7:0]  cfg_p, cfg_wl;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned root_floor(int unsigned v);
    int unsigned r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic logic [2:0] terrain_of(int unsigned lvl);
    int unsigned wl = cfg_wl;
    int unsigned lz = 255 - wl;
    if (lvl < wl / 2) return 3'd0;
    if (lvl <= wl) return 3'd1;
    if (lvl < wl + lz * 15 / 100) return 3'd2;
    if (lvl < wl + lz * 40 / 100) return 3'd3;
    if (lvl < wl + lz * 80 / 100) return 3'd4;
    return 3'd5;
  endfunction

  function automatic void splat(int cx, int cy, int w, int h);
    int r = (cfg_r > MaxRadius) ? MaxRadius : cfg_r;
    int x, y, d2, step, impact;
    longint sum;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        x = cx + dx;
        y = cy + dy;
        d2 = dx * dx + dy * dy;
        if (x < 0 || x >= w || y < 0 || y >= h || d2 > r * r) continue;
        step = root_floor(d2);
        impact = (cfg_p > step) ? cfg_p - step : 0;
        sum = longint'(height_grid[y*MaxWidth+x]) + impact;
        if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
        height_grid[y*MaxWidth+x] = sum[23:0];
        if (sum[23:0] > peak_h) peak_h = sum[23:0];
      end
    end
  endfunction

  function automatic void predict_cell(cell_cmd_t c);
    int w = (cfg_w > MaxWidth) ? MaxWidth : cfg_w;
    int h = (cfg_h > MaxHeight) ? MaxHeight : cfg_h;
    bit in_grid = (c.x < w) && (c.y < h);
    cell_answer_t a = '0;
    longint lvl;
    case (c.op)
      OpDrop: begin
        if (in_grid) splat(c.x, c.y, w, h);
        else a.status = 1'b1;
      end
      OpRead: begin
        if (in_grid) begin
          a.raw = height_grid[c.y*MaxWidth+c.x];
          lvl = 0;
          if (peak_h != 0) lvl = longint'(a.raw) * 255 / peak_h;
          if (lvl > 255) lvl = 255;
          a.level = lvl[7:0];
          a.terrain = terrain_of(a.level);
        end else begin
          a.status = 1'b1;
        end
      end
      OpClear: begin
        foreach (height_grid[i]) height_grid[i] = '0;
        peak_h = '0;
      end
      default: ;
    endcase
    answer_q.push_back(a);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_cell(cur_cmd);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cmd_q.size() > 0 && !(src_noisy && $urandom_range(99) < 35)) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {2'b00, cur_cmd.y, cur_cmd.x, cur_cmd.op};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and sink
  always @(posedge clk_i or negedge rst_ni) begin
    cell_answer_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[35:0];
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $realtime, got);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
            errors++;
          end
          if (got.raw !== want.raw) begin
            $display("%0t: raw_height expected %0d actual %0d", $realtime, want.raw, got.raw);
            errors++;
          end
          if (got.level !== want.level) begin
            $display("%0t: level expected %0d actual %0d", $realtime, want.level, got.level);
            errors++;
          end
          if (got.terrain !== want.terrain) begin
            $display("%0t: terrain expected %0d actual %0d", $realtime, want.terrain,
                     got.terrain);
            errors++;
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_req = 0;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(sink_noisy && $urandom_range(99) < 35);
      end
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (cmd_q.size() != 0 || s_axis_tvalid_i || answer_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegGridWidth:  cfg_w  = val[6:0];
      RegGridHeight: cfg_h  = val[6:0];
      RegDropRadius: cfg_r  = val[3:0];
      RegDropPower:  cfg_p  = val[7:0];
      RegWaterLevel: cfg_wl = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int r, int p, int wl);
    apb_write(RegGridWidth, w);
    apb_write(RegGridHeight, h);
    apb_write(RegDropRadius, r);
    apb_write(RegDropPower, p);
    apb_write(RegWaterLevel, wl);
  endtask

  function automatic void push_cmd(logic [1:0] op, int x, int y);
    cell_cmd_t c;
    c.op = op;
    c.x = 6'(x);
    c.y = 6'(y);
    cmd_q.push_back(c);
  endfunction

  task automatic random_burst(int n);
    int w = (cfg_w > MaxWidth) ? MaxWidth : cfg_w;
    int h = (cfg_h > MaxHeight) ? MaxHeight : cfg_h;
    int k;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      op = (k < 45) ? OpDrop : (k < 90) ? OpRead : (k < 93) ? OpClear : OpNop;
      if (w > 0 && h > 0 && $urandom_range(99) < 80)
        push_cmd(op, $urandom_range(w - 1), $urandom_range(h - 1));
      else
        push_cmd(op, $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    foreach (height_grid[i]) height_grid[i] = '0;
    peak_h = '0;
    cfg_w = 64; cfg_h = 64; cfg_r = 2; cfg_p = 2; cfg_wl = 40;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // directed: reset settings, empty grid, corners, unknown op, clear
    push_cmd(OpRead, 0, 0);
    push_cmd(OpDrop, 0, 0);
    push_cmd(OpDrop, 63, 63);
    push_cmd(OpRead, 0, 0);
    push_cmd(OpRead, 1, 1);
    push_cmd(OpRead, 63, 62);
    push_cmd(OpNop, 63, 63);
    push_cmd(OpClear, 5, 5);
    push_cmd(OpRead, 63, 63);
    wait_drained();
    set_config(64, 64, 3, 255, 40);
    push_cmd(OpDrop, 10, 10);
    push_cmd(OpDrop, 11, 10);
    for (int i = 7; i <= 14; i++) push_cmd(OpRead, i, 10);
    wait_drained();
    // shrunk grid: outside cells, peak left from outside the grid
    set_config(5, 3, 0, 0, 255);
    push_cmd(OpRead, 4, 2);
    push_cmd(OpRead, 5, 2);
    push_cmd(OpDrop, 63, 0);
    push_cmd(OpDrop, 2, 2);
    push_cmd(OpRead, 2, 2);
    wait_drained();

    set_config(64, 64, 2, 2, 40);
    random_burst(100);
    wait_drained();
    set_config(127, 100, 15, 255, 200);
    random_burst(30);
    wait_drained();
    set_config(0, 0, 0, 0, 0);
    random_burst(30);
    wait_drained();
    set_config(7, 9, 1, 1, 255);
    random_burst(100);
    wait_drained();
    src_noisy = 0;
    sink_noisy = 0;
    set_config(33, 20, 4, 17, 120);
    hold_req = 1;
    random_burst(150);
    wait_drained();
    src_noisy = 1;
    sink_noisy = 1;
    set_config(64, 1, 3, 200, 128);
    random_burst(100);
    wait_drained();
    set_config(20, 64, 5, 100, 1);
    random_burst(110);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("[heightmap_splat_classify_unit] OK");
    else $display("[heightmap_splat_classify_unit] ERROR");
    $finish;
  end

  initial begin
    #60ms;
    $display("[heightmap_splat_classify_unit] ERROR");
    $finish;
  end
endmodule
